FILE: design/rti_pkg.sv
// rti_pkg: shared types and constants for the round-to-increment unit
// depends on nothing; used by every module in the design folder
`timescale 1ns / 1ps
package rti_pkg;
  localparam int W = 64;
  localparam int SW = 63;
  localparam int NCELL = 16;
  localparam int BPC = W / NCELL;

  typedef enum logic [1:0] {
    MODE_CEIL = 2'd0,
    MODE_FLOOR = 2'd1,
    MODE_TRUNC = 2'd2,
    MODE_HALF_EXPAND = 2'd3
  } mode_t;

  typedef struct packed {
    logic [63:0] value;
    logic [62:0] step_size;
    logic [1:0] mode;
  } in_t;

  typedef struct packed {
    logic [63:0] rounded_value;
    logic overflow;
  } out_t;

  // data handed from one divider cell to the next
  typedef struct packed {
    logic vld;
    logic neg;
    logic [1:0] mode;
    logic [W-1:0] raw;
    logic [SW-1:0] step;
    logic [W-1:0] rem;
    logic [W-1:0] quo;
  } div_t;
endpackage

FILE: design/rti_cell.sv
// rti_cell: one stage of the restoring divider, retiring BPC quotient bits
// depends on rti_pkg
`timescale 1ns / 1ps
module rti_cell (
  input  logic clk,
  input  logic rst,
  input  rti_pkg::div_t d,
  output rti_pkg::div_t q
);
  import rti_pkg::*;

  div_t n;
  logic [W:0] tr;

  // shift-subtract steps for this cell's quotient bits
  always_comb begin
    n = d;
    tr = '0;
    for (int i = 0; i < BPC; i++) begin
      tr = {n.rem, n.quo[W-1]} - {2'b00, n.step};
      if (!tr[W]) begin
        n.rem = tr[W-1:0];
        n.quo = {n.quo[W-2:0], 1'b1};
      end else begin
        n.rem = {n.rem[W-2:0], n.quo[W-1]};
        n.quo = {n.quo[W-2:0], 1'b0};
      end
    end
  end

  // register toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else begin
      q.vld <= d.vld;
    end
    q.neg <= n.neg;
    q.mode <= n.mode;
    q.raw <= n.raw;
    q.step <= n.step;
    q.rem <= n.rem;
    q.quo <= n.quo;
  end
endmodule

FILE: design/rti_fix.sv
// rti_fix: quotient adjust, multiply back in 32-bit partial products, saturate
// depends on rti_pkg
`timescale 1ns / 1ps
module rti_fix (
  input  logic clk,
  input  logic rst,
  input  rti_pkg::div_t d,
  output logic strobe,
  output rti_pkg::out_t res
);
  import rti_pkg::*;

  logic away;
  logic [W-1:0] quo1;
  logic [W:0] rem2;
  logic [W-1:0] hr;

  // stage a: step away from zero by mode
  logic a_vld, a_pass, a_neg;
  logic [W-1:0] a_raw, a_quo;
  logic [SW-1:0] a_step;
  // stage b: partial products
  logic b_vld, b_pass, b_neg, b_ovq;
  logic [W-1:0] b_raw;
  logic [63:0] b_ll, b_lh, b_hl;
  // combination of partials
  logic [W+1:0] prod;
  logic ovf;
  logic [W-1:0] mag, outv;

  assign hr = {1'b1, {(W-1){1'b0}}};
  assign rem2 = {d.rem, 1'b0};

  always_comb begin
    case (mode_t'(d.mode))
      MODE_CEIL: away = !d.neg;
      MODE_FLOOR: away = d.neg;
      MODE_HALF_EXPAND: away = rem2 >= {2'b00, d.step};
      default: away = 1'b0;
    endcase
  end
  assign quo1 = d.quo + {{(W-1){1'b0}}, away};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      strobe <= 1'b0;
    end else begin
      a_vld <= d.vld;
      b_vld <= a_vld;
      strobe <= b_vld;
    end
    a_pass <= (d.step <= SW'(1)) || (d.rem == '0);
    a_neg <= d.neg;
    a_raw <= d.raw;
    a_quo <= quo1;
    a_step <= d.step;
    b_pass <= a_pass;
    b_neg <= a_neg;
    b_raw <= a_raw;
    b_ll <= 64'(a_quo[31:0]) * 64'(a_step[31:0]);
    b_lh <= 64'(a_quo[31:0]) * 64'(a_step[62:32]);
    b_hl <= 64'(a_quo[63:32]) * 64'(a_step[31:0]);
    b_ovq <= (a_quo[63:32] != '0) && (a_step[62:32] != '0);
  end

  // sum partials and saturate
  always_comb begin
    prod = {2'b00, b_ll} + ({2'b00, b_lh} << 32) + ({2'b00, b_hl} << 32);
    ovf = 1'b0;
    mag = prod[W-1:0];
    if (b_neg) begin
      if (b_ovq || prod > {2'b00, hr}) begin
        ovf = 1'b1;
        mag = hr;
      end
      outv = -mag;
    end else begin
      if (b_ovq || prod > {2'b00, hr - 1'b1}) begin
        ovf = 1'b1;
        mag = hr - 1'b1;
      end
      outv = mag;
    end
    if (b_pass) begin
      outv = b_raw;
      ovf = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res.rounded_value <= outv;
    res.overflow <= ovf;
  end

  ap_ovf_pos: assert property (@(posedge clk) disable iff (rst)
    strobe && res.overflow && !res.rounded_value[63] |-> res.rounded_value == {1'b0, {63{1'b1}}})
    else $error("positive saturation wrong");
  ap_ovf_neg: assert property (@(posedge clk) disable iff (rst)
    strobe && res.overflow && res.rounded_value[63] |-> res.rounded_value == {1'b1, 63'b0})
    else $error("negative saturation wrong");
  ap_strobe: assert property (@(posedge clk) disable iff (rst)
    a_vld |-> ##2 strobe) else $error("result lost");
endmodule

FILE: design/round_to_increment_unit.sv
// round_to_increment_unit: top level, chain of divider cells plus fix stage
// depends on rti_pkg, rti_cell, rti_fix
`timescale 1ns / 1ps
// Usage: drive in and pulse start; busy is always low, so a transfer is
// taken on every cycle that start is high, one item per cycle.
// The value's magnitude is divided by step_size in a chain of 16 cells,
// each retiring four quotient bits and registering its result; the fix
// stage then adjusts the quotient by mode, multiplies back with 32-bit
// partial products and saturates.
// Registers: 1 input register + 16 cells + 3 fix stages = 20 registers;
// strobe is registered together with the result, so both appear on the same
// edge. Throughput: one item per cycle.
// The result sits on res for one cycle with strobe high; the receiver
// cannot stall, and nothing is held back.
// Reset clears all valid bits; items in flight are dropped.
module round_to_increment_unit (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  rti_pkg::in_t in,
  output logic strobe,
  output rti_pkg::out_t res
);
  import rti_pkg::*;

  div_t chain [NCELL+1];
  logic neg;
  logic [W-1:0] mag;

  assign busy = 1'b0;
  assign neg = in.value[W-1];
  assign mag = neg ? -in.value : in.value;

  // input register feeding the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].vld <= 1'b0;
    end else begin
      chain[0].vld <= start;
    end
    chain[0].neg <= neg;
    chain[0].mode <= in.mode;
    chain[0].raw <= in.value;
    chain[0].step <= in.step_size;
    chain[0].rem <= '0;
    chain[0].quo <= mag;
  end

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    rti_cell u_cell (.clk(clk), .rst(rst), .d(chain[g]), .q(chain[g+1]));
  end

  rti_fix u_fix (.clk(clk), .rst(rst), .d(chain[NCELL]), .strobe(strobe), .res(res));
endmodule

FILE: sim/rti_checker.sv
// rti_checker: watches the command and result channels of the rounding unit,
// predicts each rounded multiple and compares it; depends on rti_pkg
`timescale 1ns / 1ps
module rti_checker (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  rti_pkg::in_t in,
  input  logic strobe,
  input  rti_pkg::out_t res,
  output int fail_count,
  output int pending
);
  import rti_pkg::*;

  out_t rounded_q[$];

  // rounded multiple of the increment, saturated on overflow
  function automatic out_t round_multiple(in_t item);
    out_t r;
    logic neg;
    logic [63:0] mag, quo, rem, prod, stp;
    logic away;
    mode_t m;
    r = '0;
    stp = {1'b0, item.step_size};
    m = mode_t'(item.mode);
    neg = item.value[63];
    mag = neg ? (64'd0 - item.value) : item.value;
    if (stp <= 64'd1) begin
      r.rounded_value = item.value;
      return r;
    end
    quo = mag / stp;
    rem = mag % stp;
    if (rem == 64'd0) begin
      r.rounded_value = item.value;
      return r;
    end
    away = 1'b0;
    case (m)
      MODE_CEIL: away = !neg;
      MODE_FLOOR: away = neg;
      MODE_HALF_EXPAND: away = ((rem << 1) >= stp);
      default: away = 1'b0;
    endcase
    if (away) quo = quo + 64'd1;
    prod = quo * stp;
    if (neg) begin
      if (prod > 64'h8000_0000_0000_0000) begin
        r.overflow = 1'b1;
        prod = 64'h8000_0000_0000_0000;
      end
      r.rounded_value = 64'd0 - prod;
    end else begin
      if (prod > 64'h7fff_ffff_ffff_ffff) begin
        r.overflow = 1'b1;
        prod = 64'h7fff_ffff_ffff_ffff;
      end
      r.rounded_value = prod;
    end
    return r;
  endfunction

  assign pending = rounded_q.size();

  // predict on each accepted transfer, compare on each strobe
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (strobe) begin
        if (rounded_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, res);
          fail_count <= fail_count + 1;
        end else begin
          want = rounded_q.pop_front();
          if (want.rounded_value !== res.rounded_value || want.overflow !== res.overflow) begin
            $display("%0t: mismatch expected value %h ovf %b, actual value %h ovf %b",
                     $time, want.rounded_value, want.overflow,
                     res.rounded_value, res.overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) rounded_q.push_back(round_multiple(in));
    end
  end
endmodule

FILE: sim/tb_top.sv
// tb_top: stimulus and verdict for the rounding unit regression
// depends on rti_pkg, round_to_increment_unit, rti_checker
`timescale 1ns / 1ps
module tb_top;
  import rti_pkg::*;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_t in;
  logic strobe;
  out_t res;
  int fail_count;
  int pending;
  int cycles;
  int idle_pct;

  round_to_increment_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in(in), .strobe(strobe), .res(res)
  );

  rti_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in(in),
    .strobe(strobe), .res(res), .fail_count(fail_count), .pending(pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 200000) begin
        $display("round_to_increment_unit regression: fail");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random step: small, random width, power of two or full width
  function automatic logic [62:0] rand_step();
    logic [62:0] s;
    case ($urandom_range(0, 4))
      0: s = 63'($urandom_range(0, 10));
      1: s = 63'($urandom_range(2, 1000));
      2: s = 63'(rand64() >> $urandom_range(1, 62));
      3: s = 63'd1 << $urandom_range(0, 62);
      default: s = 63'(rand64());
    endcase
    return s;
  endfunction

  // one command transfer, with a possible idle gap before it
  task automatic send(input logic [63:0] v, input logic [62:0] s, input mode_t m);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in <= '{value: v, step_size: s, mode: m};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic [63:0] v;
    logic [62:0] s;
    mode_t m;
    start = 1'b0;
    in = '0;
    rst = 1'b1;
    idle_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // directed: range ends, zero and unit steps, exact multiples, overflow
    for (int k = 0; k < 4; k++) begin
      m = mode_t'(k);
      send(64'h7fff_ffff_ffff_ffff, 63'd2, m);
      send(64'h8000_0000_0000_0000, 63'd3, m);
      send(64'h7fff_ffff_ffff_fffe, 63'h7fff_ffff_ffff_ffff, m);
      send(64'h8000_0000_0000_0001, 63'h7fff_ffff_ffff_ffff, m);
      send(64'd7, 63'd0, m);
      send(-64'd7, 63'd1, m);
    end
    send(64'd15, 63'd10, MODE_HALF_EXPAND);
    send(-64'd20, 63'd10, MODE_CEIL);
    // random phases: no idling, heavy idling, light idling, no idling again
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 71 : (ph == 2) ? 25 : 0;
      for (int i = 0; i < 210; i++) begin
        s = rand_step();
        case ($urandom_range(0, 3))
          0: v = rand64();
          1: v = 64'($signed(64'($urandom_range(0, 2000))) - 1000);
          2: v = $urandom_range(0, 1)
                   ? 64'h7fff_ffff_ffff_ffff - 64'($urandom_range(0, 50))
                   : 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 50));
          default: v = rand64() >> $urandom_range(0, 63);
        endcase
        send(v, s, mode_t'($urandom_range(0, 3)));
        if ($urandom_range(0, 9) == 0) begin
          start <= 1'b0;
          @(posedge clk);
        end
      end
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("round_to_increment_unit regression: pass");
    end else begin
      $display("round_to_increment_unit regression: fail");
    end
    $finish;
  end
endmodule
